>>> hdl/acr_pkg.sv
// Types, phase codes and field kinds shared by the avcC record parser.
package acr_pkg;

	localparam int HEADER_BYTES_DEF = 8;

	localparam logic [3:0] PH_SKIP      = 4'd0;
	localparam logic [3:0] PH_FIXED     = 4'd1;
	localparam logic [3:0] PH_SPS_HI    = 4'd2;
	localparam logic [3:0] PH_SPS_LO    = 4'd3;
	localparam logic [3:0] PH_SPS_BYTE  = 4'd4;
	localparam logic [3:0] PH_PPS_COUNT = 4'd5;
	localparam logic [3:0] PH_PPS_HI    = 4'd6;
	localparam logic [3:0] PH_PPS_LO    = 4'd7;
	localparam logic [3:0] PH_PPS_BYTE  = 4'd8;
	localparam logic [3:0] PH_TRAIL     = 4'd9;
	localparam logic [3:0] PH_DONE      = 4'd10;

	localparam logic [3:0] KIND_VERSION     = 4'd0;
	localparam logic [3:0] KIND_PROFILE     = 4'd1;
	localparam logic [3:0] KIND_COMPAT      = 4'd2;
	localparam logic [3:0] KIND_LEVEL       = 4'd3;
	localparam logic [3:0] KIND_LENSIZE     = 4'd4;
	localparam logic [3:0] KIND_SPSCOUNT    = 4'd5;
	localparam logic [3:0] KIND_SPSLEN      = 4'd6;
	localparam logic [3:0] KIND_SPSBYTE     = 4'd7;
	localparam logic [3:0] KIND_PPSCOUNT    = 4'd8;
	localparam logic [3:0] KIND_PPSLEN      = 4'd9;
	localparam logic [3:0] KIND_PPSBYTE     = 4'd10;
	localparam logic [3:0] KIND_CHROMA      = 4'd11;
	localparam logic [3:0] KIND_LUMADEPTH   = 4'd12;
	localparam logic [3:0] KIND_CHROMADEPTH = 4'd13;
	localparam logic [3:0] KIND_EXTCOUNT    = 4'd14;

	localparam logic [7:0] MASK_LENSIZE = 8'h03;
	localparam logic [7:0] MASK_COUNT   = 8'h1F;
	localparam logic [7:0] MASK_DEPTH   = 8'h07;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       first_byte;
	} byte_item_t;

	typedef struct packed {
		logic [3:0]  field_kind;
		logic [15:0] field_value;
		logic [7:0]  set_index;
		logic [15:0] byte_position;
		logic        last_of_set;
	} field_item_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [3:0]  header_count;
		logic [7:0]  sets_remaining;
		logic [7:0]  current_set;
		logic [7:0]  length_high;
		logic [15:0] payload_remaining;
		logic [15:0] payload_position;
	} parse_state_t;

endpackage

>>> hdl/avc_config_record_parser.sv
// Top level of the avcC record parser: input register, parse state and result register.
// A byte is held in the input register; its field item, if any, goes to the result register.
// Throughput: one byte per cycle but for stalls; the parse state updates in a single step
// per byte. A byte that yields a field waits in the input register while the result register
// is stalled; bytes that yield nothing pass through without waiting. Reset: asynchronous,
// active low; clears both valid flags, enters header skip (fixed fields if HEADER_BYTES=0).
module avc_config_record_parser import acr_pkg::*; #(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  byte_item_t  byte_item,
	output logic        field_valid,
	input  logic        field_stall,
	output field_item_t field_item
);

	byte_item_t   item_s1;
	logic         valid_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         emit;
	field_item_t  result;
	logic         field_valid_q;
	field_item_t  field_item_q;
	logic         advance;

	acr_step #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_step (
		.state_cur(state_q),
		.item(item_s1),
		.state_nxt(state_nxt),
		.emit(emit),
		.result(result)
	);

	assign advance = valid_s1 && (!emit || !field_valid_q || !field_stall);
	assign byte_stall = valid_s1 && !advance;
	assign field_valid = field_valid_q;
	assign field_item = field_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: (HEADER_BYTES == 0) ? PH_FIXED : PH_SKIP, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_valid_q <= 1'b0;
		end else if (advance && emit) begin
			field_valid_q <= 1'b1;
		end else if (!field_stall) begin
			field_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			field_item_q <= result;
		end
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && field_valid_q && field_stall)
		else $error("input stalled without a blocked field item");

	a_last_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && field_item.last_of_set |->
		field_item.field_kind == KIND_SPSBYTE || field_item.field_kind == KIND_PPSBYTE)
		else $error("last_of_set on a non-payload field");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid |-> field_item.field_kind <= KIND_EXTCOUNT)
		else $error("field kind out of range");

	a_hold_unaccepted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit && field_valid_q && field_stall |=> valid_s1 && $stable(item_s1))
		else $error("blocked byte lost from input register");

endmodule

>>> hdl/acr_step.sv
// Next-state and result logic of the record parser for one byte.
module acr_step import acr_pkg::*; #(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  parse_state_t state_cur,
	input  byte_item_t   item,
	output parse_state_t state_nxt,
	output logic         emit,
	output field_item_t  result
);

	parse_state_t st;
	logic [7:0]   b;
	logic [4:0]   hc_inc;
	logic [15:0]  len;
	logic [7:0]   sr_dec;
	logic [15:0]  pr_dec;

	always_comb begin
		b = item.byte_value;
		st = state_cur;
		if (item.first_byte) begin
			st = '0;
			st.phase = (HEADER_BYTES == 0) ? PH_FIXED : PH_SKIP;
		end
		hc_inc = {1'b0, st.header_count} + 5'd1;
		len = {st.length_high, b};
		sr_dec = st.sets_remaining - 8'd1;
		pr_dec = st.payload_remaining - 16'd1;

		state_nxt = st;
		emit = 1'b0;
		result = '0;
		result.field_value = {8'd0, b};

		case (st.phase)
			PH_SKIP: begin
				if (hc_inc >= 5'(HEADER_BYTES)) begin
					state_nxt.phase = PH_FIXED;
					state_nxt.header_count = '0;
				end else begin
					state_nxt.header_count = hc_inc[3:0];
				end
			end
			PH_FIXED: begin
				emit = 1'b1;
				state_nxt.header_count = hc_inc[3:0];
				case (st.header_count)
					4'd0: result.field_kind = KIND_VERSION;
					4'd1: result.field_kind = KIND_PROFILE;
					4'd2: result.field_kind = KIND_COMPAT;
					4'd3: result.field_kind = KIND_LEVEL;
					4'd4: begin
						result.field_kind = KIND_LENSIZE;
						result.field_value = {8'd0, b & MASK_LENSIZE};
					end
					default: begin
						result.field_kind = KIND_SPSCOUNT;
						result.field_value = {8'd0, b & MASK_COUNT};
						state_nxt.sets_remaining = b & MASK_COUNT;
						state_nxt.current_set = '0;
						state_nxt.header_count = '0;
						state_nxt.phase = ((b & MASK_COUNT) == 8'd0) ? PH_PPS_COUNT : PH_SPS_HI;
					end
				endcase
			end
			PH_SPS_HI, PH_PPS_HI: begin
				state_nxt.length_high = b;
				state_nxt.phase = st.phase + 4'd1;
			end
			PH_SPS_LO, PH_PPS_LO: begin
				emit = 1'b1;
				result.field_kind = (st.phase == PH_SPS_LO) ? KIND_SPSLEN : KIND_PPSLEN;
				result.field_value = len;
				result.set_index = st.current_set;
				state_nxt.payload_remaining = len;
				state_nxt.payload_position = '0;
				if (len == 16'd0) begin
					state_nxt.current_set = st.current_set + 8'd1;
					state_nxt.sets_remaining = sr_dec;
					if (st.phase == PH_SPS_LO) begin
						state_nxt.phase = (sr_dec == 8'd0) ? PH_PPS_COUNT : PH_SPS_HI;
						if (sr_dec == 8'd0) begin
							state_nxt.current_set = '0;
						end
					end else begin
						state_nxt.phase = (sr_dec == 8'd0) ? PH_TRAIL : PH_PPS_HI;
					end
				end else begin
					state_nxt.phase = (st.phase == PH_SPS_LO) ? PH_SPS_BYTE : PH_PPS_BYTE;
				end
			end
			PH_SPS_BYTE, PH_PPS_BYTE: begin
				emit = 1'b1;
				result.field_kind = (st.phase == PH_SPS_BYTE) ? KIND_SPSBYTE : KIND_PPSBYTE;
				result.set_index = st.current_set;
				result.byte_position = st.payload_position;
				result.last_of_set = (st.payload_remaining == 16'd1);
				state_nxt.payload_position = st.payload_position + 16'd1;
				state_nxt.payload_remaining = pr_dec;
				if (pr_dec == 16'd0) begin
					state_nxt.current_set = st.current_set + 8'd1;
					state_nxt.sets_remaining = sr_dec;
					if (st.phase == PH_SPS_BYTE) begin
						state_nxt.phase = (sr_dec == 8'd0) ? PH_PPS_COUNT : PH_SPS_HI;
						if (sr_dec == 8'd0) begin
							state_nxt.current_set = '0;
						end
					end else begin
						state_nxt.phase = (sr_dec == 8'd0) ? PH_TRAIL : PH_PPS_HI;
					end
				end
			end
			PH_PPS_COUNT: begin
				emit = 1'b1;
				result.field_kind = KIND_PPSCOUNT;
				state_nxt.sets_remaining = b;
				state_nxt.current_set = '0;
				state_nxt.header_count = '0;
				state_nxt.phase = (b == 8'd0) ? PH_TRAIL : PH_PPS_HI;
			end
			PH_TRAIL: begin
				emit = 1'b1;
				state_nxt.header_count = hc_inc[3:0];
				case (st.header_count)
					4'd0: begin
						result.field_kind = KIND_CHROMA;
						result.field_value = {8'd0, b & MASK_LENSIZE};
					end
					4'd1: begin
						result.field_kind = KIND_LUMADEPTH;
						result.field_value = {8'd0, b & MASK_DEPTH};
					end
					4'd2: begin
						result.field_kind = KIND_CHROMADEPTH;
						result.field_value = {8'd0, b & MASK_DEPTH};
					end
					default: begin
						result.field_kind = KIND_EXTCOUNT;
						state_nxt.header_count = '0;
						state_nxt.phase = PH_DONE;
					end
				endcase
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

endmodule
